// ===== rtl/mmst_pkg.sv =====
// ----------------------------------------------------------------------------
// mmst_pkg
// Types and codes shared by the multi-mouse state tracker modules.
// ----------------------------------------------------------------------------
package mmst_pkg;

    // Request kinds as they arrive on the input channel.
    localparam logic [2:0] KIND_ATTACH = 3'd0;
    localparam logic [2:0] KIND_DETACH = 3'd1;
    localparam logic [2:0] KIND_REPORT = 3'd2;
    localparam logic [2:0] KIND_QUERY  = 3'd3;
    localparam logic [2:0] KIND_RANK   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]        kind;
        logic [6:0]        address;
        logic [2:0]        rank;
        logic [7:0]        buttons;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [7:0] delta_wheel;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         slot;
        logic [14:0]        pos_x;
        logic [14:0]        pos_y;
        logic signed [15:0] wheel_pos;
        logic [7:0]         button_state;
        logic [2:0]         mice_present;
        logic [6:0]         found_address;
    } res_t;

    // Operation decided by the front.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ATTACH,
        OP_DETACH,
        OP_REPORT,
        OP_QUERY,
        OP_RANK,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [6:0]        address;
        logic [2:0]        rank;
        logic [7:0]        buttons;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [7:0] delta_wheel;
    } cmd_t;

endpackage

// ===== rtl/multi_mouse_state_tracker_core.sv =====
// ----------------------------------------------------------------------------
// multi_mouse_state_tracker_core
// Tracks position, wheel and buttons of up to SLOTS mice by device address.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on req/req_valid/req_ready and is one of attach,
//   detach, report, query by address or address by rank. Every request
//   gives exactly one result on res/res_valid/res_ready, in request order.
//   The front classifies a request in the cycle it is accepted and places
//   it in a two-entry queue; the back takes one request a cycle from the
//   queue while its result register is free or being taken, updates the
//   slot table and registers the result.
//   A result passes through the queue entry and then the result register
//   before res_valid rises, and one request a cycle is sustained while the
//   output is not stalled.
//   Reset empties the table and the queue and drops res_valid.
//   When the receiver stalls, the result is held in the output register,
//   the queue fills with up to two further requests, and req_ready then
//   falls until the result is taken.
// ----------------------------------------------------------------------------
module multi_mouse_state_tracker_core #(
    parameter int unsigned SLOTS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mmst_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output mmst_pkg::res_t res
);
    import mmst_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    mmst_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mmst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mmst_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== rtl/mmst_front.sv =====
// ----------------------------------------------------------------------------
// mmst_front
// Accepts requests and classifies them into operations for the back.
// ----------------------------------------------------------------------------
module mmst_front (
    input  logic           req_valid,
    output logic           req_ready,
    input  mmst_pkg::req_t req,
    output logic           push_valid,
    input  logic           push_ready,
    output mmst_pkg::cmd_t push_data
);
    import mmst_pkg::*;

    op_t op;

    // Address zero never names a mouse, so any request that needs one is
    // turned into a plain rejection here.
    always_comb
    begin
        case (req.kind)
            KIND_ATTACH: op = (req.address == 7'd0) ? OP_REJECT : OP_ATTACH;
            KIND_DETACH: op = (req.address == 7'd0) ? OP_REJECT : OP_DETACH;
            KIND_REPORT: op = (req.address == 7'd0) ? OP_REJECT : OP_REPORT;
            KIND_QUERY:  op = (req.address == 7'd0) ? OP_REJECT : OP_QUERY;
            KIND_RANK:   op = OP_RANK;
            default:     op = OP_NOP;
        endcase
    end

    always_comb
    begin
        push_data.op          = op;
        push_data.address     = req.address;
        push_data.rank        = req.rank;
        push_data.buttons     = req.buttons;
        push_data.delta_x     = req.delta_x;
        push_data.delta_y     = req.delta_y;
        push_data.delta_wheel = req.delta_wheel;
    end

    assign push_valid = req_valid;
    assign req_ready  = push_ready;

endmodule

// ===== rtl/mmst_queue.sv =====
// ----------------------------------------------------------------------------
// mmst_queue
// Short first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
module mmst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mmst_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mmst_pkg::cmd_t pop_data
);
    import mmst_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mmst_back.sv =====
// ----------------------------------------------------------------------------
// mmst_back
// Holds the slot table, carries out one operation a cycle while the result
// register is free or taken and registers the result for the output channel.
// ----------------------------------------------------------------------------
module mmst_back #(
    parameter int unsigned SLOTS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  mmst_pkg::cmd_t pop_data,
    output logic           res_valid,
    input  logic           res_ready,
    output mmst_pkg::res_t res
);
    import mmst_pkg::*;

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned RW = CW + 3;

    logic [6:0]  addr_reg   [SLOTS];
    logic [14:0] x_reg      [SLOTS];
    logic [14:0] y_reg      [SLOTS];
    logic [15:0] wheel_reg  [SLOTS];
    logic [7:0]  btn_reg    [SLOTS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic    res_valid_reg;
    res_t    res_reg;
    res_t    res_next;

    logic          fire;
    logic          match_hit;
    logic [IW-1:0] match_idx;
    logic          free_hit;
    logic [IW-1:0] free_idx;
    logic          rank_hit;
    logic [IW-1:0] rank_idx;
    logic [RW-1:0] seen;

    logic          sel_ok;
    logic [IW-1:0] sel_idx;
    logic [IW+1:0] sel_ext;
    logic [RW-1:0] count_ext;
    logic          show;
    logic [6:0]    found;
    logic [1:0]    status;

    logic [14:0] new_x;
    logic [14:0] new_y;
    logic [15:0] new_wheel;

    logic wr_attach;
    logic wr_detach;
    logic wr_report;

    // Adds a signed byte to a position and holds the sum within 0..32767.
    function automatic logic [14:0] clamp_add(input logic [14:0] pos, input logic [7:0] d);
        logic [16:0] sum;
        sum = {2'b00, pos} + {{9{d[7]}}, d};
        if (sum[16])
        begin
            clamp_add = '0;
        end
        else if (sum[15])
        begin
            clamp_add = '1;
        end
        else
        begin
            clamp_add = sum[14:0];
        end
    endfunction

    assign fire      = pop_valid && pop_ready;
    assign pop_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Lowest slot holding the address, lowest free slot, and the slot of the
    // requested rank among occupied slots in slot order.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        rank_hit  = 1'b0;
        rank_idx  = '0;
        seen      = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!match_hit && addr_reg[i] == pop_data.address)
            begin
                match_hit = 1'b1;
                match_idx = IW'(i);
            end
            if (!free_hit && addr_reg[i] == 7'd0)
            begin
                free_hit = 1'b1;
                free_idx = IW'(i);
            end
            if (addr_reg[i] != 7'd0)
            begin
                if (!rank_hit && seen == {{CW{1'b0}}, pop_data.rank})
                begin
                    rank_hit = 1'b1;
                    rank_idx = IW'(i);
                end
                seen = seen + 1'b1;
            end
        end
    end

    always_comb
    begin
        sel_ok    = 1'b0;
        sel_idx   = '0;
        show      = 1'b0;
        found     = '0;
        status    = ST_OK;
        wr_attach = 1'b0;
        wr_detach = 1'b0;
        wr_report = 1'b0;
        case (pop_data.op)
            OP_ATTACH:
            begin
                sel_ok    = free_hit;
                sel_idx   = free_idx;
                show      = free_hit;
                wr_attach = free_hit;
                status    = free_hit ? ST_OK : ST_FULL;
            end
            OP_DETACH:
            begin
                sel_ok    = match_hit;
                sel_idx   = match_idx;
                wr_detach = match_hit;
                status    = match_hit ? ST_OK : ST_MISSING;
            end
            OP_REPORT:
            begin
                sel_ok    = match_hit;
                sel_idx   = match_idx;
                show      = match_hit;
                wr_report = match_hit;
                status    = match_hit ? ST_OK : ST_MISSING;
            end
            OP_QUERY:
            begin
                sel_ok  = match_hit;
                sel_idx = match_idx;
                show    = match_hit;
                status  = match_hit ? ST_OK : ST_MISSING;
            end
            OP_RANK:
            begin
                sel_ok  = rank_hit;
                sel_idx = rank_idx;
                found   = rank_hit ? addr_reg[rank_idx] : 7'd0;
                status  = rank_hit ? ST_OK : ST_MISSING;
            end
            OP_REJECT:
            begin
                status = ST_MISSING;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign new_x     = clamp_add(x_reg[sel_idx], pop_data.delta_x);
    assign new_y     = clamp_add(y_reg[sel_idx], pop_data.delta_y);
    assign new_wheel = wheel_reg[sel_idx] + {{8{pop_data.delta_wheel[7]}}, pop_data.delta_wheel};

    always_comb
    begin
        count_next = count_reg;
        if (wr_attach)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (wr_detach && count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign sel_ext   = {2'b00, (sel_ok ? sel_idx : {IW{1'b0}})};
    assign count_ext = {3'b000, count_next};

    always_comb
    begin
        res_next.status        = status;
        res_next.slot          = sel_ext[1:0];
        res_next.pos_x         = '0;
        res_next.pos_y         = '0;
        res_next.wheel_pos     = '0;
        res_next.button_state  = '0;
        res_next.mice_present  = count_ext[2:0];
        res_next.found_address = found;
        if (show)
        begin
            if (wr_report)
            begin
                res_next.pos_x        = new_x;
                res_next.pos_y        = new_y;
                res_next.wheel_pos    = new_wheel;
                res_next.button_state = pop_data.buttons;
            end
            else if (!wr_attach)
            begin
                res_next.pos_x        = x_reg[sel_idx];
                res_next.pos_y        = y_reg[sel_idx];
                res_next.wheel_pos    = wheel_reg[sel_idx];
                res_next.button_state = btn_reg[sel_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                addr_reg[i]  <= '0;
                x_reg[i]     <= '0;
                y_reg[i]     <= '0;
                wheel_reg[i] <= '0;
                btn_reg[i]   <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                res_valid_reg <= 1'b1;
                count_reg     <= count_next;
                if (wr_attach)
                begin
                    addr_reg[sel_idx]  <= pop_data.address;
                    x_reg[sel_idx]     <= '0;
                    y_reg[sel_idx]     <= '0;
                    wheel_reg[sel_idx] <= '0;
                    btn_reg[sel_idx]   <= '0;
                end
                if (wr_detach)
                begin
                    addr_reg[sel_idx] <= '0;
                end
                if (wr_report)
                begin
                    x_reg[sel_idx]     <= new_x;
                    y_reg[sel_idx]     <= new_y;
                    wheel_reg[sel_idx] <= new_wheel;
                    btn_reg[sel_idx]   <= pop_data.buttons;
                end
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule
